// ===== rtl/core/lqxm_pkg.sv =====
package lqxm_pkg;

  // field widths
  localparam int GainW   = 16;
  localparam int CoeffW  = 32;
  localparam int StateW  = 32;
  localparam int SqW     = 48;
  localparam int RootW   = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  // square root unit: result bits produced per clock
  localparam int SqrtStepsPerCycle = 2;
  localparam int SqrtIters = RootW / SqrtStepsPerCycle;
  localparam int SqrtCntW  = $clog2(SqrtIters + 1);

  // register reset values
  localparam logic [GainW-1:0]  ThrustGainRst = 16'd1311;
  localparam logic [GainW-1:0]  TorqueGainRst = 16'd1311;
  localparam logic [CoeffW-1:0] InvThrustRst  = 32'd6400000;
  localparam logic [CoeffW-1:0] InvArmRst     = 32'd36000000;
  localparam logic [CoeffW-1:0] InvYawRst     = 32'd640000000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgThrustGain = 3'd0,
    CfgTorqueGain = 3'd1,
    CfgInvThrust  = 3'd2,
    CfgInvArm     = 3'd3,
    CfgInvYaw     = 3'd4
  } cfg_idx_e;

  // tick request payload
  typedef struct packed {
    logic signed [StateW-1:0] desired_thrust;
    logic signed [StateW-1:0] desired_torque_x;
    logic signed [StateW-1:0] desired_torque_y;
    logic signed [StateW-1:0] desired_torque_z;
  } lqxm_req_t;

  // rotor speed result payload
  typedef struct packed {
    logic [RootW-1:0] rotor_speed_0;
    logic [RootW-1:0] rotor_speed_1;
    logic [RootW-1:0] rotor_speed_2;
    logic [RootW-1:0] rotor_speed_3;
    logic             speed_saturated;
  } lqxm_rsp_t;

endpackage

// ===== rtl/core/lqxm_req_if.sv =====
interface lqxm_req_if;
  logic                  valid;
  logic                  ready;
  lqxm_pkg::lqxm_req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lqxm_rsp_if.sv =====
interface lqxm_rsp_if;
  logic                  valid;
  logic                  ready;
  lqxm_pkg::lqxm_rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lqxm_isqrt.sv =====
module lqxm_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lqxm_pkg::SqW-1:0]    radicand_i,
  output logic                        done_o,
  output logic [lqxm_pkg::RootW-1:0]  root_o
);

  logic [lqxm_pkg::SqW-1:0]      rad_q, rad_v;
  logic [lqxm_pkg::RootW+3:0]    rem_q, rem_v, rem_t;
  logic [lqxm_pkg::RootW+4:0]    trial;
  logic [lqxm_pkg::RootW-1:0]    root_q, root_v;
  logic [lqxm_pkg::SqrtCntW-1:0] cnt_q;
  logic                          done_q;

  // restoring digit recurrence, two radicand bits per result bit
  always_comb begin
    rad_v  = rad_q;
    rem_v  = rem_q;
    root_v = root_q;
    rem_t  = '0;
    trial  = '0;
    for (int i = 0; i < lqxm_pkg::SqrtStepsPerCycle; i++) begin
      rem_t = {rem_v[lqxm_pkg::RootW+1:0], rad_v[lqxm_pkg::SqW-1 -: 2]};
      rad_v = {rad_v[lqxm_pkg::SqW-3:0], 2'b00};
      trial = {1'b0, rem_t} - {3'b000, root_v, 2'b01};
      if (!trial[lqxm_pkg::RootW+4]) begin
        rem_v  = trial[lqxm_pkg::RootW+3:0];
        root_v = {root_v[lqxm_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_v  = rem_t;
        root_v = {root_v[lqxm_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // iteration count and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == lqxm_pkg::SqrtCntW'(1));
      if (start_i) begin
        cnt_q <= lqxm_pkg::SqrtCntW'(lqxm_pkg::SqrtIters);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - lqxm_pkg::SqrtCntW'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_v;
      rem_q  <= rem_v;
      root_q <= root_v;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/lagged_quad_x_motor_mixer.sv =====
// Lagged X-quadrotor motor mixer. Each accepted tick request moves the four lag
// states (thrust and three torques, signed Q16.16) toward the request by the
// configured Q0.16 gains, mixes the updated states through the inverse X mixing
// matrix with the three Q24.8 coefficients, clamps each squared speed to
// [0, 2^48-1] (speed_saturated flags the upper clamp) and returns the four Q16.8
// rotor speeds as one result. A single 33x33 multiplier and a single 66-bit
// adder are shared under a sequencer, and the square root runs two result bits
// per clock. After a request is accepted the sequencer runs the lag updates
// (difference, gain product and update for each state), the four products,
// the four partial sums, then per rotor the final sum, the square root start,
// the root iterations and the done pulse, and last loads the output register
// once it is free. The next request is taken in the cycle after that load. The
// block takes no new request while a tick is in work; it does take one while
// the previous result still waits at the output register. Registers may be
// written only while the block is idle.
module lagged_quad_x_motor_mixer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lqxm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lqxm_pkg::CfgDataW-1:0]  cfg_data_i,
  lqxm_req_if.sink                       req_i,
  lqxm_rsp_if.source                     rsp_o
);

  // sequencer codes
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDiff = 4'd1;
  localparam logic [3:0] StLmul = 4'd2;
  localparam logic [3:0] StLadd = 4'd3;
  localparam logic [3:0] StPmul = 4'd4;
  localparam logic [3:0] StPre  = 4'd5;
  localparam logic [3:0] StMix  = 4'd6;
  localparam logic [3:0] StSqst = 4'd7;
  localparam logic [3:0] StRoot = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;

  logic [lqxm_pkg::GainW-1:0]  thrust_gain_q, torque_gain_q;
  logic [lqxm_pkg::CoeffW-1:0] inv_thrust_q, inv_arm_q, inv_yaw_q;

  logic [lqxm_pkg::StateW-1:0] tgt_q  [4];
  logic [lqxm_pkg::StateW-1:0] filt_q [4];
  logic signed [32:0]          diff_q;
  logic [63:0]                 prod_q;
  logic [63:0]                 p_q   [4];
  logic [64:0]                 pre_q [4];
  logic [65:0]                 mix_q;
  logic [lqxm_pkg::RootW-1:0]  speed_q [4];
  logic                        sat_q;

  logic                  rsp_valid_q;
  lqxm_pkg::lqxm_rsp_t   rsp_q;

  logic req_acc, rsp_load;

  logic signed [65:0] add_a, add_b, add_res;
  logic               add_sub;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_res;
  logic [lqxm_pkg::GainW-1:0]  gain_sel;
  logic [lqxm_pkg::CoeffW-1:0] coeff_sel;

  logic                        sq_neg, sq_over, sq_start, sq_done;
  logic [lqxm_pkg::SqW-1:0]    sq_rad;
  logic [lqxm_pkg::RootW-1:0]  sq_root;

  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == StDone) && (!rsp_valid_q || rsp_o.ready);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thrust_gain_q <= lqxm_pkg::ThrustGainRst;
      torque_gain_q <= lqxm_pkg::TorqueGainRst;
      inv_thrust_q  <= lqxm_pkg::InvThrustRst;
      inv_arm_q     <= lqxm_pkg::InvArmRst;
      inv_yaw_q     <= lqxm_pkg::InvYawRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lqxm_pkg::CfgThrustGain: thrust_gain_q <= cfg_data_i[lqxm_pkg::GainW-1:0];
        lqxm_pkg::CfgTorqueGain: torque_gain_q <= cfg_data_i[lqxm_pkg::GainW-1:0];
        lqxm_pkg::CfgInvThrust:  inv_thrust_q  <= cfg_data_i;
        lqxm_pkg::CfgInvArm:     inv_arm_q     <= cfg_data_i;
        lqxm_pkg::CfgInvYaw:     inv_yaw_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // gain and coefficient for the current channel
  always_comb begin
    gain_sel = (idx_q == 2'd0) ? thrust_gain_q : torque_gain_q;
    case (idx_q)
      2'd0:    coeff_sel = inv_thrust_q;
      2'd3:    coeff_sel = inv_yaw_q;
      default: coeff_sel = inv_arm_q;
    endcase
  end

  // shared adder: lag difference, lag update, partial sums, rotor sums
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      StDiff: begin
        add_a   = {{34{tgt_q[idx_q][31]}}, tgt_q[idx_q]};
        add_b   = {{34{filt_q[idx_q][31]}}, filt_q[idx_q]};
        add_sub = 1'b1;
      end
      StLadd: begin
        add_a = {{34{filt_q[idx_q][31]}}, filt_q[idx_q]};
        add_b = {{33{prod_q[48]}}, prod_q[48:16]};
      end
      StPre: begin
        // thrust +/- yaw, roll -/+ pitch
        if (idx_q[1]) begin
          add_a = {{2{p_q[1][63]}}, p_q[1]};
          add_b = {{2{p_q[2][63]}}, p_q[2]};
        end else begin
          add_a = {{2{p_q[0][63]}}, p_q[0]};
          add_b = {{2{p_q[3][63]}}, p_q[3]};
        end
        add_sub = idx_q[1] ^ idx_q[0];
      end
      StMix: begin
        // rotors 0,1 use thrust+yaw with roll-pitch, rotors 2,3 the others
        if (idx_q[1]) begin
          add_a = {pre_q[1][64], pre_q[1]};
          add_b = {pre_q[3][64], pre_q[3]};
          add_sub = !idx_q[0];
        end else begin
          add_a = {pre_q[0][64], pre_q[0]};
          add_b = {pre_q[2][64], pre_q[2]};
          add_sub = idx_q[0];
        end
      end
      default: ;
    endcase
    add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  // shared multiplier: lag step and mixing products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StLmul: begin
        mul_a = diff_q;
        mul_b = {17'b0, gain_sel};
      end
      StPmul: begin
        mul_a = {filt_q[idx_q][31], filt_q[idx_q]};
        mul_b = {1'b0, coeff_sel};
      end
      default: ;
    endcase
    mul_res = mul_a * mul_b;
  end

  // floor to Q32.16 then clamp
  assign sq_neg  = mix_q[65];
  assign sq_over = !mix_q[65] && (|mix_q[64:56]);
  assign sq_rad  = sq_neg ? '0 : (sq_over ? '1 : mix_q[55:8]);

  lqxm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    sq_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_acc) begin
          state_d = StDiff;
          idx_d   = 2'd0;
        end
      end
      StDiff: state_d = StLmul;
      StLmul: state_d = StLadd;
      StLadd: begin
        idx_d   = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? StPmul : StDiff;
      end
      StPmul: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = StPre;
      end
      StPre: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = StMix;
      end
      StMix: state_d = StSqst;
      StSqst: begin
        sq_start = 1'b1;
        state_d  = StRoot;
      end
      StRoot: begin
        if (sq_done) begin
          idx_d   = idx_q + 2'd1;
          state_d = (idx_q == 2'd3) ? StDone : StMix;
        end
      end
      StDone: begin
        if (rsp_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control state, lag states, flag and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= 2'd0;
      sat_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        filt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (req_acc) begin
        sat_q <= 1'b0;
      end else if (state_q == StSqst && sq_over) begin
        sat_q <= 1'b1;
      end
      if (state_q == StLadd) begin
        filt_q[idx_q] <= add_res[31:0];
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      tgt_q[0] <= req_i.data.desired_thrust;
      tgt_q[1] <= req_i.data.desired_torque_x;
      tgt_q[2] <= req_i.data.desired_torque_y;
      tgt_q[3] <= req_i.data.desired_torque_z;
    end
    case (state_q)
      StDiff: diff_q <= add_res[32:0];
      StLmul: prod_q <= mul_res[63:0];
      StPmul: p_q[idx_q] <= mul_res[63:0];
      StPre:  pre_q[idx_q] <= add_res[64:0];
      StMix:  mix_q <= add_res;
      StRoot: begin
        if (sq_done) speed_q[idx_q] <= sq_root;
      end
      default: ;
    endcase
    if (rsp_load) begin
      rsp_q.rotor_speed_0   <= speed_q[0];
      rsp_q.rotor_speed_1   <= speed_q[1];
      rsp_q.rotor_speed_2   <= speed_q[2];
      rsp_q.rotor_speed_3   <= speed_q[3];
      rsp_q.speed_saturated <= sat_q;
    end
  end

  // checks
  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == StRoot)
    else $error("square root finished outside the root phase");

  a_accept_starts_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == StDiff) && (idx_q == 2'd0))
    else $error("accepted request did not start the lag update");

  a_lag_to_products: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLadd) && (idx_q == 2'd3) |=> (state_q == StPmul) && (idx_q == 2'd0))
    else $error("lag phase did not hand over to the products");

  a_sat_has_full_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.speed_saturated |->
      (&rsp_o.data.rotor_speed_0) || (&rsp_o.data.rotor_speed_1) ||
      (&rsp_o.data.rotor_speed_2) || (&rsp_o.data.rotor_speed_3))
    else $error("saturation flag without a full-scale rotor speed");

endmodule

// ===== dv/tb_lagged_quad_x_motor_mixer.sv =====
module tb_lagged_quad_x_motor_mixer;

  localparam int CycleLimit  = 1_200_000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles  = 1500;
  localparam int MaxReports  = 10;

  // widths taken from the package
  localparam int StateW   = lqxm_pkg::StateW;
  localparam int SqW      = lqxm_pkg::SqW;
  localparam int RootW    = lqxm_pkg::RootW;
  localparam int GainW    = lqxm_pkg::GainW;
  localparam int CoeffW   = lqxm_pkg::CoeffW;
  localparam int CfgIdxW  = lqxm_pkg::CfgIdxW;
  localparam int CfgDataW = lqxm_pkg::CfgDataW;

  // full-scale signed Q16.16 targets
  localparam logic signed [StateW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [StateW-1:0] QMin = 32'sh8000_0000;

  // largest squared speed that fits Q32.16
  localparam logic signed [67:0] SqMax = {20'd0, {SqW{1'b1}}};

  // sign of each torque term per rotor row, bit j is rotor j
  localparam bit [3:0] RollPos  = 4'b1001;
  localparam bit [3:0] PitchPos = 4'b1010;
  localparam bit [3:0] YawPos   = 4'b0011;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lqxm_req_if req_ch ();
  lqxm_rsp_if rsp_ch ();

  lagged_quad_x_motor_mixer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // mirror of the mixer registers and lag states
  logic [GainW-1:0]         gain_thrust = lqxm_pkg::ThrustGainRst;
  logic [GainW-1:0]         gain_torque = lqxm_pkg::TorqueGainRst;
  logic [CoeffW-1:0]        coef_thrust = lqxm_pkg::InvThrustRst;
  logic [CoeffW-1:0]        coef_arm    = lqxm_pkg::InvArmRst;
  logic [CoeffW-1:0]        coef_yaw    = lqxm_pkg::InvYawRst;
  logic signed [StateW-1:0] lag_thrust  = '0;
  logic signed [StateW-1:0] lag_torque [3] = '{default: '0};

  lqxm_pkg::lqxm_rsp_t expected_speeds [$];
  lqxm_pkg::lqxm_rsp_t want;
  lqxm_pkg::lqxm_rsp_t got;
  int unsigned mismatch_cnt = 0;
  int unsigned hold_left    = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one first-order lag step, floor of the scaled error
  function automatic logic signed [StateW-1:0] lag_step(logic signed [StateW-1:0] cur,
                                                        logic signed [StateW-1:0] tgt,
                                                        logic [GainW-1:0] g);
    longint err;
    longint moved;
    err   = longint'(tgt) - longint'(cur);
    moved = (err * longint'(g)) >>> 16;
    return StateW'(longint'(cur) + moved);
  endfunction

  // exact Q16.16 times Q24.8 product
  function automatic logic signed [67:0] scale_by(logic signed [StateW-1:0] v,
                                                  logic [CoeffW-1:0] c);
    logic signed [67:0] a;
    logic signed [67:0] b;
    a = v;
    b = {1'b0, c};
    return a * b;
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic logic [RootW-1:0] int_sqrt(logic [SqW-1:0] v);
    logic [RootW-1:0] r;
    logic [RootW-1:0] t;
    r = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      t = r | (RootW'(1) << b);
      if (SqW'(t) * SqW'(t) <= v) r = t;
    end
    return r;
  endfunction

  // advance the lag states and mix them into four rotor speeds
  function automatic lqxm_pkg::lqxm_rsp_t predict_tick(lqxm_pkg::lqxm_req_t req);
    logic signed [67:0]  p_t;
    logic signed [67:0]  p_x;
    logic signed [67:0]  p_y;
    logic signed [67:0]  p_z;
    logic signed [67:0]  acc;
    logic signed [67:0]  sq;
    logic [RootW-1:0]    root;
    lqxm_pkg::lqxm_rsp_t r;
    lag_thrust    = lag_step(lag_thrust, req.desired_thrust, gain_thrust);
    lag_torque[0] = lag_step(lag_torque[0], req.desired_torque_x, gain_torque);
    lag_torque[1] = lag_step(lag_torque[1], req.desired_torque_y, gain_torque);
    lag_torque[2] = lag_step(lag_torque[2], req.desired_torque_z, gain_torque);
    p_t = scale_by(lag_thrust, coef_thrust);
    p_x = scale_by(lag_torque[0], coef_arm);
    p_y = scale_by(lag_torque[1], coef_arm);
    p_z = scale_by(lag_torque[2], coef_yaw);
    r = '0;
    for (int j = 0; j < 4; j++) begin
      acc = p_t + (RollPos[j] ? p_x : -p_x) + (PitchPos[j] ? p_y : -p_y)
                + (YawPos[j] ? p_z : -p_z);
      sq = acc >>> 8;
      // negative squares clamp quietly, oversized ones saturate and flag
      if (sq < 0) begin
        sq = '0;
      end else if (sq > SqMax) begin
        sq = SqMax;
        r.speed_saturated = 1'b1;
      end
      root = int_sqrt(SqW'(sq));
      case (j)
        0: r.rotor_speed_0 = root;
        1: r.rotor_speed_1 = root;
        2: r.rotor_speed_2 = root;
        default: r.rotor_speed_3 = root;
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // mix of full-scale, full-range and scaled-down targets
  function automatic logic signed [StateW-1:0] rand_q16();
    logic [StateW-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 19))
      0: return QMax;
      1: return QMin;
      2: return '0;
      3, 4, 5, 6: return raw;
      default: return signed'(raw) >>> $urandom_range(4, 30);
    endcase
  endfunction

  function automatic logic [GainW-1:0] rand_gain();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return raw[GainW-1:0];
      default: return GainW'($urandom_range(100, 8000));
    endcase
  endfunction

  function automatic logic [CoeffW-1:0] rand_coeff(logic [CoeffW-1:0] base);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(base / 8, base * 2);
    endcase
  endfunction

  function automatic lqxm_pkg::lqxm_req_t make_req(logic signed [StateW-1:0] t,
                                                   logic signed [StateW-1:0] x,
                                                   logic signed [StateW-1:0] y,
                                                   logic signed [StateW-1:0] z);
    lqxm_pkg::lqxm_req_t r;
    r.desired_thrust   = t;
    r.desired_torque_x = x;
    r.desired_torque_y = y;
    r.desired_torque_z = z;
    return r;
  endfunction

  function automatic lqxm_pkg::lqxm_req_t rand_req();
    return make_req(rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  function void report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) $display("%0t: %s", $time, msg);
  endfunction

  // one register write, called at a falling edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      lqxm_pkg::CfgThrustGain: gain_thrust = val[GainW-1:0];
      lqxm_pkg::CfgTorqueGain: gain_torque = val[GainW-1:0];
      lqxm_pkg::CfgInvThrust:  coef_thrust = val;
      lqxm_pkg::CfgInvArm:     coef_arm    = val;
      lqxm_pkg::CfgInvYaw:     coef_yaw    = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // gains go out with junk in the upper bits, which the block must drop
  task automatic set_mixer_cfg(logic [GainW-1:0] g_t, logic [GainW-1:0] g_q,
                               logic [CoeffW-1:0] c_t, logic [CoeffW-1:0] c_a,
                               logic [CoeffW-1:0] c_y);
    write_reg(lqxm_pkg::CfgThrustGain, {16'($urandom), g_t});
    write_reg(lqxm_pkg::CfgTorqueGain, {16'($urandom), g_q});
    write_reg(lqxm_pkg::CfgInvThrust, c_t);
    write_reg(lqxm_pkg::CfgInvArm, c_a);
    write_reg(lqxm_pkg::CfgInvYaw, c_y);
  endtask

  // offer one tick request, called at a falling edge
  task automatic send_tick(lqxm_pkg::lqxm_req_t req);
    int unsigned gap;
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_speeds.push_back(predict_tick(req));
    @(negedge clk_i);
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop offering and let every pending tick come back
  task automatic drain_ticks();
    req_ch.valid <= 1'b0;
    while (expected_speeds.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_tick(make_req('0, '0, '0, '0));
    send_tick(make_req(32'sd655360, 32'sd65536, -32'sd65536, 32'sd32768));
    send_tick(make_req(-32'sd655360, '0, '0, '0));
    drain_ticks();
  endtask

  // state jumps almost to the target with full gain
  task automatic test_field_extremes();
    set_mixer_cfg('1, '1, lqxm_pkg::InvThrustRst, lqxm_pkg::InvArmRst,
                  lqxm_pkg::InvYawRst);
    send_tick(make_req(QMax, '0, '0, '0));
    send_tick(make_req(QMin, '0, '0, '0));
    send_tick(make_req('0, QMax, '0, '0));
    send_tick(make_req('0, QMin, '0, '0));
    send_tick(make_req('0, '0, QMax, '0));
    send_tick(make_req('0, '0, QMin, '0));
    send_tick(make_req('0, '0, '0, QMax));
    send_tick(make_req('0, '0, '0, QMin));
    send_tick(make_req(QMax, QMax, QMax, QMax));
    send_tick(make_req(QMin, QMin, QMin, QMin));
    drain_ticks();
    set_mixer_cfg('1, '1, '1, '1, '1);
    send_tick(make_req(QMax, '0, '0, '0));
    send_tick(make_req(QMax, QMin, QMax, QMin));
    drain_ticks();
  endtask

  // zero gain freezes the states, zero coefficients drop their terms
  task automatic test_zero_gain_and_coeff();
    set_mixer_cfg('0, '0, lqxm_pkg::InvThrustRst, lqxm_pkg::InvArmRst,
                  lqxm_pkg::InvYawRst);
    send_tick(rand_req());
    send_tick(make_req(QMin, QMax, QMin, QMax));
    drain_ticks();
    set_mixer_cfg('1, '1, '0, '0, '0);
    send_tick(rand_req());
    send_tick(make_req(QMax, QMax, QMax, QMax));
    drain_ticks();
    set_mixer_cfg(16'd30000, 16'd30000, lqxm_pkg::InvThrustRst, '0, lqxm_pkg::InvYawRst);
    send_tick(make_req(32'sd3276800, QMax, QMin, 32'sd65536));
    drain_ticks();
  endtask

  // writes to unused indexes must not disturb any register
  task automatic test_cfg_index_and_width();
    set_mixer_cfg(16'd4000, 16'd9000, lqxm_pkg::InvThrustRst, lqxm_pkg::InvArmRst,
                  lqxm_pkg::InvYawRst);
    for (int i = int'(lqxm_pkg::CfgInvYaw) + 1; i < 2 ** CfgIdxW; i++) begin
      write_reg(CfgIdxW'(i), $urandom);
    end
    send_tick(make_req(32'sd1310720, 32'sd6553, -32'sd6553, 32'sd655));
    send_tick(rand_req());
    drain_ticks();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    set_mixer_cfg(16'd20000, 16'd20000, lqxm_pkg::InvThrustRst, lqxm_pkg::InvArmRst,
                  lqxm_pkg::InvYawRst);
    tx_idle_en = 1'b0;
    hold_left  = HoldCycles;
    for (int n = 0; n < 8; n++) send_tick(rand_req());
    drain_ticks();
    tx_idle_en = 1'b1;
  endtask

  // phases of held targets with occasional jumps, under varied settings
  task automatic test_random_mix();
    lqxm_pkg::lqxm_req_t tgt;
    tgt = rand_req();
    for (int p = 0; p < 12; p++) begin
      drain_ticks();
      case (p)
        0: set_mixer_cfg('1, '1, '1, '1, '1);
        1: set_mixer_cfg(16'd1, 16'd1, 32'd1, 32'd1, 32'd1);
        2: set_mixer_cfg(lqxm_pkg::ThrustGainRst, lqxm_pkg::TorqueGainRst,
                         lqxm_pkg::InvThrustRst, lqxm_pkg::InvArmRst,
                         lqxm_pkg::InvYawRst);
        default: set_mixer_cfg(rand_gain(), rand_gain(),
                               rand_coeff(lqxm_pkg::InvThrustRst),
                               rand_coeff(lqxm_pkg::InvArmRst),
                               rand_coeff(lqxm_pkg::InvYawRst));
      endcase
      tx_idle_en = (p % 4 != 3);
      rx_idle_en = (p % 3 != 2);
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 9) < 3) tgt.desired_thrust   = rand_q16();
        if ($urandom_range(0, 9) < 3) tgt.desired_torque_x = rand_q16();
        if ($urandom_range(0, 9) < 3) tgt.desired_torque_y = rand_q16();
        if ($urandom_range(0, 9) < 3) tgt.desired_torque_z = rand_q16();
        send_tick(tgt);
      end
    end
    drain_ticks();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // result side ready with random stalls and the long hold
  initial begin : rsp_ready_gen
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rx_idle_en) stall_left = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_speeds.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", got));
      end else begin
        want = expected_speeds.pop_front();
        if (got.rotor_speed_0 !== want.rotor_speed_0)
          report_mismatch($sformatf("rotor_speed_0 exp %0d got %0d",
                                    want.rotor_speed_0, got.rotor_speed_0));
        if (got.rotor_speed_1 !== want.rotor_speed_1)
          report_mismatch($sformatf("rotor_speed_1 exp %0d got %0d",
                                    want.rotor_speed_1, got.rotor_speed_1));
        if (got.rotor_speed_2 !== want.rotor_speed_2)
          report_mismatch($sformatf("rotor_speed_2 exp %0d got %0d",
                                    want.rotor_speed_2, got.rotor_speed_2));
        if (got.rotor_speed_3 !== want.rotor_speed_3)
          report_mismatch($sformatf("rotor_speed_3 exp %0d got %0d",
                                    want.rotor_speed_3, got.rotor_speed_3));
        if (got.speed_saturated !== want.speed_saturated)
          report_mismatch($sformatf("speed_saturated exp %0b got %0b",
                                    want.speed_saturated, got.speed_saturated));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_lagged_quad_x_motor_mixer: done, errors");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_zero_gain_and_coeff();
    test_cfg_index_and_width();
    test_backpressure();
    test_random_mix();

    drain_ticks();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_lagged_quad_x_motor_mixer: done, clean");
    end else begin
      $display("tb_lagged_quad_x_motor_mixer: done, errors");
    end
    $finish;
  end

endmodule
